// ===== rtl/itc_pkg.sv =====
// Package with the shared types, codes and sizes of the interval timer counters.
`default_nettype none
package itc_pkg;

    localparam int NUM_COUNTERS = 3;

    localparam int CTR_IDX_W  = 2;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int OP_MODE_W  = 3;
    localparam int ERR_W      = 3;
    localparam int OUT_LVL_W  = 3;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CTRL  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_READ_BACK = 3'd1,
        ERR_ACCESS    = 3'd2,
        ERR_OP_MODE   = 3'd3,
        ERR_BCD       = 3'd4
    } err_t;

    // Control word field codes.
    localparam logic [1:0] SEL_READ_BACK = 2'd3;
    localparam logic [1:0] RW_LATCH      = 2'd0;
    localparam logic [1:0] RW_LOW_HIGH   = 2'd3;

    localparam logic [OP_MODE_W-1:0] MODE_INT_TC   = 3'd0;
    localparam logic [OP_MODE_W-1:0] MODE_RATE_GEN = 3'd2;
    localparam logic [OP_MODE_W-1:0] MODE_SQ_WAVE  = 3'd3;

    localparam logic [COUNT_W-1:0] HIGH_MASK = 16'hFF00;
    localparam logic [COUNT_W-1:0] LOW_MASK  = 16'h00FF;

    typedef struct packed {
        logic [1:0]           mode;
        logic [CTR_IDX_W-1:0] counter_index;
        logic [BYTE_W-1:0]    data;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_data;
        logic [ERR_W-1:0]     error_code;
        logic [OUT_LVL_W-1:0] outputs_high;
    } out_item_t;

    // One command for one counter, decoded from the current item.
    typedef struct packed {
        logic                 write;
        logic                 read;
        logic                 latch;
        logic                 set_mode;
        logic                 tick;
        logic [BYTE_W-1:0]    data;
        logic [OP_MODE_W-1:0] op_mode;
    } ctr_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/itc_if.sv =====
// Handshake interfaces for the item and result channels of the timer.
`default_nettype none
interface itc_in_if;
    logic             valid;
    logic             ready;
    itc_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface itc_out_if;
    logic              valid;
    logic              ready;
    itc_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/itc_decode.sv =====
// Decoder that turns one item into per-counter commands and an error code.
`default_nettype none
module itc_decode (
    input  wire logic               fire,
    input  wire itc_pkg::in_item_t  item,
    output itc_pkg::ctr_cmd_t       cmd [itc_pkg::NUM_COUNTERS],
    output itc_pkg::err_t           err
);

    logic [1:0]                    sel;
    logic [1:0]                    rw;
    logic [itc_pkg::OP_MODE_W-1:0] md;
    logic                          bcd;
    logic                          is_ctrl;
    logic                          latch_req;
    logic                          mode_req;

    assign sel     = item.data[7:6];
    assign rw      = item.data[5:4];
    assign md      = item.data[3:1];
    assign bcd     = item.data[0];
    assign is_ctrl = (item.mode == itc_pkg::KIND_CTRL);

    // The checks run in a fixed priority; a failing word changes no state.
    always_comb
    begin
        err       = itc_pkg::ERR_OK;
        latch_req = 1'b0;
        mode_req  = 1'b0;
        if (is_ctrl)
        begin
            if (sel == itc_pkg::SEL_READ_BACK)
                err = itc_pkg::ERR_READ_BACK;
            else if (rw == itc_pkg::RW_LATCH)
                latch_req = 1'b1;
            else if (rw != itc_pkg::RW_LOW_HIGH)
                err = itc_pkg::ERR_ACCESS;
            else if (!(md inside {itc_pkg::MODE_INT_TC, itc_pkg::MODE_RATE_GEN,
                                  itc_pkg::MODE_SQ_WAVE}))
                err = itc_pkg::ERR_OP_MODE;
            else if (bcd)
                err = itc_pkg::ERR_BCD;
            else
                mode_req = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < itc_pkg::NUM_COUNTERS; i++)
        begin
            cmd[i].write    = fire && (item.mode == itc_pkg::KIND_WRITE) &&
                              (item.counter_index == itc_pkg::CTR_IDX_W'(i));
            cmd[i].read     = fire && (item.mode == itc_pkg::KIND_READ) &&
                              (item.counter_index == itc_pkg::CTR_IDX_W'(i));
            cmd[i].latch    = fire && latch_req && (sel == 2'(i));
            cmd[i].set_mode = fire && mode_req && (sel == 2'(i));
            cmd[i].tick     = fire && (item.mode == itc_pkg::KIND_TICK);
            cmd[i].data     = item.data;
            cmd[i].op_mode  = md;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/itc_counter.sv =====
// One timer counter: count, latch, byte order flags, down count and output level.
`default_nettype none
module itc_counter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire itc_pkg::ctr_cmd_t            cmd,
    output logic [itc_pkg::BYTE_W-1:0]        rd_byte,
    output logic                              level_next
);

    logic [itc_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [itc_pkg::COUNT_W-1:0]   latched_reg, latched_next;
    logic [itc_pkg::COUNT_W-1:0]   remain_reg, remain_next;
    logic                          armed_reg, armed_next;
    logic [itc_pkg::OP_MODE_W-1:0] op_mode_reg, op_mode_next;
    logic                          level_reg;
    logic                          latch_act_reg, latch_act_next;
    logic                          rd_high_reg, rd_high_next;
    logic                          wr_high_reg, wr_high_next;
    logic [itc_pkg::COUNT_W-1:0]   read_src;
    logic [itc_pkg::COUNT_W-1:0]   count_hi_wr;
    logic [itc_pkg::COUNT_W-1:0]   remain_dec;

    assign read_src    = latch_act_reg ? latched_reg : count_reg;
    assign count_hi_wr = (count_reg & itc_pkg::LOW_MASK) |
                         {cmd.data, {itc_pkg::BYTE_W{1'b0}}};
    assign remain_dec  = remain_reg - itc_pkg::COUNT_W'(1);

    always_comb
    begin
        rd_byte = '0;
        if (cmd.read)
            rd_byte = rd_high_reg ? read_src[15:8] : read_src[7:0];
    end

    always_comb
    begin
        count_next     = count_reg;
        latched_next   = latched_reg;
        remain_next    = remain_reg;
        armed_next     = armed_reg;
        op_mode_next   = op_mode_reg;
        level_next     = level_reg;
        latch_act_next = latch_act_reg;
        rd_high_next   = rd_high_reg;
        wr_high_next   = wr_high_reg;
        if (cmd.write)
        begin
            if (!wr_high_reg)
            begin
                count_next   = (count_reg & itc_pkg::HIGH_MASK) |
                               {{itc_pkg::BYTE_W{1'b0}}, cmd.data};
                armed_next   = 1'b0;
                level_next   = 1'b0;
                wr_high_next = 1'b1;
            end
            else
            begin
                count_next   = count_hi_wr;
                // A zero count leaves the counter disarmed.
                if (count_hi_wr != '0)
                begin
                    remain_next = count_hi_wr;
                    armed_next  = 1'b1;
                end
                wr_high_next = 1'b0;
            end
        end
        else if (cmd.read)
        begin
            if (!rd_high_reg)
                rd_high_next = 1'b1;
            else
            begin
                rd_high_next   = 1'b0;
                latch_act_next = 1'b0;
            end
        end
        else if (cmd.latch)
        begin
            // A second latch before both bytes are read is ignored.
            if (!latch_act_reg)
            begin
                latch_act_next = 1'b1;
                rd_high_next   = 1'b0;
                latched_next   = count_reg;
            end
        end
        else if (cmd.set_mode)
            op_mode_next = cmd.op_mode;
        else if (cmd.tick && armed_reg)
        begin
            remain_next = remain_dec;
            if (remain_dec == '0)
            begin
                armed_next = 1'b0;
                if (op_mode_reg == itc_pkg::MODE_INT_TC)
                    level_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            latched_reg   <= '0;
            remain_reg    <= '0;
            armed_reg     <= 1'b0;
            op_mode_reg   <= itc_pkg::MODE_INT_TC;
            level_reg     <= 1'b0;
            latch_act_reg <= 1'b0;
            rd_high_reg   <= 1'b0;
            wr_high_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            latched_reg   <= latched_next;
            remain_reg    <= remain_next;
            armed_reg     <= armed_next;
            op_mode_reg   <= op_mode_next;
            level_reg     <= level_next;
            latch_act_reg <= latch_act_next;
            rd_high_reg   <= rd_high_next;
            wr_high_reg   <= wr_high_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/interval_timer_counters_unit.sv =====
// Three-counter interval timer subset: each item is a bus access or a timer tick.
//
// Channels: item (sink) carries mode, counter_index and data; result (source)
// carries read_data, error_code and outputs_high. Every accepted item gives
// exactly one result, in order. A transfer happens when valid and ready are
// both high at a rising edge of clk.
// Pipeline: an accepted item sits in the input register and its result is
// loaded into the result register once that register is free or being taken,
// and the result then shows valid from the result register.
// Throughput: one item per cycle while results are taken; all per-counter
// state is updated by the decode and counter logic between the two registers.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more item, after which item.ready drops until the
// result is taken.
// Reset (rst_n low, asynchronous): both registers empty, and all counts,
// latches, byte order flags, operating modes and output levels cleared.
`default_nettype none
module interval_timer_counters_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itc_in_if.sink     item,
    itc_out_if.source  result
);

    logic               in_valid_reg;
    itc_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    itc_pkg::out_item_t out_item_reg, out_item_next;
    logic               advance;
    logic               fire;

    itc_pkg::ctr_cmd_t              cmd [itc_pkg::NUM_COUNTERS];
    itc_pkg::err_t                  err;
    logic [itc_pkg::BYTE_W-1:0]     rd_byte [itc_pkg::NUM_COUNTERS];
    logic [itc_pkg::NUM_COUNTERS-1:0] level_next;
    logic [itc_pkg::OUT_LVL_W-1:0]  levels;
    logic [itc_pkg::BYTE_W-1:0]     rd_any;

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    itc_decode u_decode (
        .fire (fire),
        .item (in_item_reg),
        .cmd  (cmd),
        .err  (err)
    );

    for (genvar i = 0; i < itc_pkg::NUM_COUNTERS; i++)
    begin : g_ctr
        itc_counter u_counter (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[i]),
            .rd_byte    (rd_byte[i]),
            .level_next (level_next[i])
        );
    end

    for (genvar j = 0; j < itc_pkg::OUT_LVL_W; j++)
    begin : g_lvl
        if (j < itc_pkg::NUM_COUNTERS)
        begin : g_on
            assign levels[j] = level_next[j];
        end
        else
        begin : g_off
            assign levels[j] = 1'b0;
        end
    end

    // Only the addressed counter drives a nonzero byte.
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < itc_pkg::NUM_COUNTERS; i++)
            rd_any = rd_any | rd_byte[i];
    end

    always_comb
    begin
        out_item_next.read_data    = rd_any;
        out_item_next.error_code   = err;
        out_item_next.outputs_high = levels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= item.payload;
        if (fire)
            out_item_reg <= out_item_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

endmodule
`default_nettype wire

// ===== rtl/itc_checker.sv =====
// Port-level checker for the interval timer counters unit, with its bind.
`default_nettype none
module itc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_read_data,
    input wire logic [2:0] out_error_code,
    input wire logic [2:0] out_levels
);

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
            $stable(out_error_code) && $stable(out_levels))
        else $error("result changed while stalled");

    // With the result side empty, the block must take a new item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while result register is empty");

    // Every item transfer is followed by a valid result on the result side.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result after an item transfer");

    // Error codes come only from control words, which never return read data.
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_error_code != 3'd0) |-> (out_read_data == 8'd0) &&
            (out_error_code <= 3'd4))
        else $error("bad error code or read data with an error");

endmodule

bind interval_timer_counters_unit itc_checker u_itc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_read_data  (result.payload.read_data),
    .out_error_code (result.payload.error_code),
    .out_levels     (result.payload.outputs_high)
);
`default_nettype wire
